### hw/rtl/gioj_pkg.sv
// ----------------------------------------------------------------------------
// gioj_pkg
// Shared types and constants of the grouped interval overlap join.
// ----------------------------------------------------------------------------
package gioj_pkg;

	localparam int GROUP_DEPTH_DEF = 64;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_MIN_LEN = 1'b0;

	localparam logic [1:0] ST_PAIR  = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_OVFL  = 2'd2;

	typedef struct packed {
		logic        new_set;
		logic [31:0] group_key;
		logic [31:0] person_id;
		logic [7:0]  chromosome;
		logic [7:0]  haplotype;
		logic [31:0] seg_start;
		logic [31:0] seg_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] id_high;
		logic [31:0] id_low;
		logic [7:0]  pair_chromosome;
		logic [31:0] shared_start;
		logic [31:0] shared_end;
		logic [31:0] shared_length;
		logic [7:0]  hap_high;
		logic [7:0]  hap_low;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [31:0] id;
		logic [7:0]  chrom;
		logic [7:0]  hap;
		logic [31:0] seg_start;
		logic [31:0] seg_end;
	} entry_t;

endpackage

### hw/rtl/gioj_mem.sv
// ----------------------------------------------------------------------------
// gioj_mem
// Group record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gioj_mem #(
	parameter int DEPTH = gioj_pkg::GROUP_DEPTH_DEF,
	parameter int IW    = $clog2(gioj_pkg::GROUP_DEPTH_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  gioj_pkg::entry_t wdata,
	input  logic             re,
	input  logic [IW-1:0]    raddr,
	output gioj_pkg::entry_t rdata
);

	gioj_pkg::entry_t mem [DEPTH];
	gioj_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/gioj_pair.sv
// ----------------------------------------------------------------------------
// gioj_pair
// Intersects a stored record with the new record and forms the pair result.
// ----------------------------------------------------------------------------
module gioj_pair (
	input  gioj_pkg::entry_t    stored,
	input  gioj_pkg::entry_t    rec,
	input  logic [31:0]         min_len,
	output logic                hit,
	output gioj_pkg::out_item_t res
);

	logic [31:0] sh_start;
	logic [31:0] sh_end;
	logic [32:0] len;
	logic        nonempty;

	assign sh_start = (stored.seg_start > rec.seg_start) ? stored.seg_start : rec.seg_start;
	assign sh_end   = (stored.seg_end < rec.seg_end) ? stored.seg_end : rec.seg_end;
	assign nonempty = sh_start <= sh_end;
	assign len      = {1'b0, sh_end} - {1'b0, sh_start} + 33'd1;
	assign hit      = nonempty && (len >= {1'b0, min_len});

	always_comb begin
		res                 = '0;
		res.status          = gioj_pkg::ST_PAIR;
		res.pair_chromosome = stored.chrom;
		res.shared_start    = sh_start;
		res.shared_end      = sh_end;
		res.shared_length   = len[32] ? '1 : len[31:0];
		res.last            = 1'b0;
		if (stored.id >= rec.id) begin
			res.id_high  = stored.id;
			res.id_low   = rec.id;
			res.hap_high = stored.hap;
			res.hap_low  = rec.hap;
		end else begin
			res.id_high  = rec.id;
			res.id_low   = stored.id;
			res.hap_high = rec.hap;
			res.hap_low  = stored.hap;
		end
	end

endmodule

### hw/rtl/grouped_interval_overlap_join.sv
// ----------------------------------------------------------------------------
// grouped_interval_overlap_join
// Joins segment records of one group key and reports overlapping pairs.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (in_item_t)
//  out     | output    | out_valid/out_stall| out_data (out_item_t)
//  cfg     | input     | APB write/read     | min_shared_length at 0x0
//
//  A record with n stored group mates is scanned with n + 1 reads of the
//  single store read port, followed by one compare stage and a flush state.
//  Order and overflow errors go straight to the flush state.
//  Reset clears control state only; the store needs no clearing pass.
//  Output stalls pause the scan once the one-entry hold register is full.
// ----------------------------------------------------------------------------
module grouped_interval_overlap_join #(
	parameter int GROUP_DEPTH = gioj_pkg::GROUP_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  gioj_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gioj_pkg::out_item_t           out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gioj_pkg::APB_AW-1:0]   paddr,
	input  logic [gioj_pkg::APB_DW-1:0]   pwdata,
	output logic [gioj_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int IW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
	localparam int CW = $clog2(GROUP_DEPTH + 1);

	typedef enum logic [2:0] {
		FSM_IDLE  = 3'b001,
		FSM_SCAN  = 3'b010,
		FSM_FLUSH = 3'b100
	} fsm_t;

	fsm_t                state_q;
	logic [31:0]         cur_key_q;
	logic                have_q;
	logic [CW-1:0]       count_q;
	logic [31:0]         min_len_q;
	logic                iss_on_q;
	logic                rd_valid_s1;
	logic                rd_last_s1;
	logic                hold_valid_q;
	gioj_pkg::out_item_t hold_q;
	logic                out_valid_q;
	gioj_pkg::out_item_t out_q;
	gioj_pkg::entry_t    rec_q;
	logic [IW-1:0]       ptr_q;
	logic [IW-1:0]       last_idx_q;

	logic                in_xfer;
	logic                have_eff;
	logic                order_err;
	logic                open_grp;
	logic [CW-1:0]       cnt_eff;
	logic                ovf;
	logic                wr_en;
	gioj_pkg::entry_t    in_entry;
	gioj_pkg::out_item_t err_res;
	gioj_pkg::entry_t    rd_entry;
	logic                hit;
	gioj_pkg::out_item_t pair_res;
	logic                out_free;
	logic                adv;
	logic                ren;
	logic                push_out;
	gioj_pkg::out_item_t push_data;
	logic                cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == gioj_pkg::REG_MIN_LEN);
	assign prdata   = (paddr[2] == gioj_pkg::REG_MIN_LEN) ? min_len_q : '0;

	assign in_stall = (state_q != FSM_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	assign have_eff  = have_q && !in_data.new_set;
	assign order_err = have_eff && (in_data.group_key < cur_key_q);
	assign open_grp  = !have_eff || (in_data.group_key != cur_key_q);
	assign cnt_eff   = open_grp ? '0 : count_q;
	assign ovf       = (cnt_eff == CW'(GROUP_DEPTH));
	assign wr_en     = in_xfer && !order_err && !ovf;

	assign in_entry.id        = in_data.person_id;
	assign in_entry.chrom     = in_data.chromosome;
	assign in_entry.hap       = in_data.haplotype;
	assign in_entry.seg_start = in_data.seg_start;
	assign in_entry.seg_end   = in_data.seg_end;

	always_comb begin
		err_res        = '0;
		err_res.status = order_err ? gioj_pkg::ST_ORDER : gioj_pkg::ST_OVFL;
		err_res.last   = 1'b1;
	end

	gioj_mem #(
		.DEPTH (GROUP_DEPTH),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_eff[IW-1:0]),
		.wdata (in_entry),
		.re    (ren),
		.raddr (ptr_q),
		.rdata (rd_entry)
	);

	gioj_pair u_pair (
		.stored  (rd_entry),
		.rec     (rec_q),
		.min_len (min_len_q),
		.hit     (hit),
		.res     (pair_res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = !(rd_valid_s1 && hit && hold_valid_q && !out_free);
	assign ren      = (state_q == FSM_SCAN) && iss_on_q && adv;

	always_comb begin
		push_out  = 1'b0;
		push_data = hold_q;
		unique case (state_q)
			FSM_SCAN: begin
				if (rd_valid_s1 && hit && hold_valid_q && out_free) begin
					push_out = 1'b1;
				end
			end
			FSM_FLUSH: begin
				if (hold_valid_q && out_free) begin
					push_out       = 1'b1;
					push_data.last = 1'b1;
				end
			end
			default: begin
				push_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FSM_IDLE;
			cur_key_q    <= '0;
			have_q       <= 1'b0;
			count_q      <= '0;
			min_len_q    <= 32'd1;
			iss_on_q     <= 1'b0;
			rd_valid_s1  <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				min_len_q <= pwdata;
			end
			if (push_out) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				FSM_IDLE: begin
					if (in_xfer) begin
						if (order_err) begin
							hold_valid_q <= 1'b1;
							state_q      <= FSM_FLUSH;
						end else begin
							have_q    <= 1'b1;
							cur_key_q <= in_data.group_key;
							if (ovf) begin
								count_q      <= cnt_eff;
								hold_valid_q <= 1'b1;
								state_q      <= FSM_FLUSH;
							end else begin
								count_q     <= cnt_eff + CW'(1);
								iss_on_q    <= 1'b1;
								rd_valid_s1 <= 1'b0;
								state_q     <= FSM_SCAN;
							end
						end
					end
				end
				FSM_SCAN: begin
					if (adv) begin
						// the last read was issued at an earlier advance, so iss_on_q is low here
						rd_valid_s1 <= iss_on_q;
						if (iss_on_q) begin
							iss_on_q <= (ptr_q != last_idx_q);
						end
						if (rd_valid_s1 && hit) begin
							hold_valid_q <= 1'b1;
						end
						if (rd_valid_s1 && rd_last_s1) begin
							state_q <= FSM_FLUSH;
						end
					end
				end
				FSM_FLUSH: begin
					if (!hold_valid_q || out_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_q <= push_data;
		end
		unique case (state_q)
			FSM_IDLE: begin
				if (in_xfer) begin
					rec_q      <= in_entry;
					ptr_q      <= '0;
					last_idx_q <= cnt_eff[IW-1:0];
					hold_q     <= err_res;
				end
			end
			FSM_SCAN: begin
				if (adv) begin
					rd_last_s1 <= (ptr_q == last_idx_q);
					if (iss_on_q) begin
						ptr_q <= ptr_q + IW'(1);
					end
					if (rd_valid_s1 && hit) begin
						hold_q <= pair_res;
					end
				end
			end
			default: begin
				rd_last_s1 <= 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/gioj_chk.sv
// ----------------------------------------------------------------------------
// gioj_chk
// Port-level checks of the grouped interval overlap join, bound to the top.
// ----------------------------------------------------------------------------
module gioj_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input gioj_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transfer changed");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != gioj_pkg::ST_PAIR) |-> out_data.last)
		else $error("error result without last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != gioj_pkg::ST_PAIR) |->
		(out_data.id_high == '0) && (out_data.shared_length == '0))
		else $error("error result carries pair data");

	a_pair_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == gioj_pkg::ST_PAIR) |->
		(out_data.shared_start <= out_data.shared_end) &&
		(out_data.id_high >= out_data.id_low) && (out_data.shared_length != '0))
		else $error("malformed pair result");

endmodule

bind grouped_interval_overlap_join gioj_chk u_gioj_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
